// ===== hdl/lbps_pkg.sv =====
// Package for the LED blink pattern sequencer: command codes, beat layouts,
// the preset pattern table and the colour-to-pin render function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbps_pkg;

	// Command codes carried in the operation field.
	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_PRESET = 3'd1;
	localparam logic [2:0] OP_CUSTOM = 3'd2;
	localparam logic [2:0] OP_SOLID  = 3'd3;
	localparam logic [2:0] OP_OFF    = 3'd4;

	// Preset indexes.
	localparam logic [2:0] PRE_OFF        = 3'd0;
	localparam logic [2:0] PRE_INIT       = 3'd1;
	localparam logic [2:0] PRE_CONNECTING = 3'd2;
	localparam logic [2:0] PRE_CONNECTED  = 3'd3;
	localparam logic [2:0] PRE_TRANSMIT   = 3'd4;
	localparam logic [2:0] PRE_BUFFERING  = 3'd5;
	localparam logic [2:0] PRE_ERROR      = 3'd6;
	localparam logic [2:0] PRE_LOWPOWER   = 3'd7;

	// Configuration register indexes.
	localparam logic CFG_BRIGHTNESS = 1'b0;
	localparam logic CFG_ENABLE     = 1'b1;

	// Main state shown while a custom pattern was last started.
	localparam logic [3:0] STATE_CUSTOM = 4'd8;

	// Lit gap used when a pattern's off time is zero, in ms.
	localparam logic [15:0] GAP_MS = 16'd100;

	// Channel level above which a pin lights when no channel dominates.
	localparam logic [7:0] MIX_LEVEL = 8'd128;

	localparam int IN_BYTES  = 9;
	localparam int OUT_BYTES = 2;

	// One input beat, fields from the highest bit down.
	typedef struct packed {
		logic [1:0]  pad;
		logic [7:0]  repeats;
		logic [15:0] off_time;
		logic [15:0] on_time;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [2:0]  preset;
		logic [2:0]  operation;
	} in_item_t;

	// One result beat, fields from the highest bit down.
	typedef struct packed {
		logic [6:0] pad;
		logic [3:0] indicated_state;
		logic       animating;
		logic       led_blue;
		logic       led_green;
		logic       led_red;
		logic       led_any;
	} out_item_t;

	// A blink pattern: colour as {red, green, blue}, times in ms.
	typedef struct packed {
		logic [23:0] colour;
		logic [15:0] on_ms;
		logic [15:0] off_ms;
		logic [7:0]  rep;
	} pattern_t;

	// Preset pattern table.
	function automatic pattern_t preset_pattern(input logic [2:0] idx);
		pattern_t p;
		unique case (idx)
			PRE_OFF:        p = '{24'h000000, 16'd0,    16'd0,    8'd0};
			PRE_INIT:       p = '{24'hFFFF00, 16'd500,  16'd500,  8'd0};
			PRE_CONNECTING: p = '{24'h0000FF, 16'd200,  16'd800,  8'd0};
			PRE_CONNECTED:  p = '{24'h00FF00, 16'd1000, 16'd0,    8'd1};
			PRE_TRANSMIT:   p = '{24'h00FFFF, 16'd100,  16'd0,    8'd1};
			PRE_BUFFERING:  p = '{24'hFFA500, 16'd250,  16'd250,  8'd2};
			PRE_ERROR:      p = '{24'hFF0000, 16'd100,  16'd100,  8'd0};
			PRE_LOWPOWER:   p = '{24'h640064, 16'd2000, 16'd8000, 8'd0};
			default:        p = '0;
		endcase
		return p;
	endfunction

	// Scale one channel by brightness/255. The quotient of a 16-bit product by
	// 255 is (x + (x >> 8) + 1) >> 8, exact over the whole product range.
	function automatic logic [7:0] scale_channel(input logic [7:0] v, input logic [7:0] br);
		logic [15:0] prod;
		logic [16:0] sum;
		prod = v * br;
		sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
		return sum[15:8];
	endfunction

	// Map a colour to the pins {blue, green, red, any}.
	function automatic logic [3:0] render(input logic [23:0] rgb, input logic [7:0] br);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [3:0] p;
		r = scale_channel(rgb[23:16], br);
		g = scale_channel(rgb[15:8], br);
		b = scale_channel(rgb[7:0], br);
		p = 4'b0000;
		if ((r != 8'd0) || (g != 8'd0) || (b != 8'd0)) begin
			p[0] = 1'b1;
			priority if ((r > g) && (r > b)) begin
				p[1] = 1'b1;
			end else if ((g > r) && (g > b)) begin
				p[2] = 1'b1;
			end else if ((b > r) && (b > g)) begin
				p[3] = 1'b1;
			end else begin
				p[1] = (r > MIX_LEVEL);
				p[2] = (g > MIX_LEVEL);
				p[3] = (b > MIX_LEVEL);
			end
		end
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/led_blink_pattern_sequencer.sv =====
// Top level of the LED blink pattern sequencer: input register, command and
// pattern step logic, result register with stream handshakes.
// Depends on lbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One beat in gives one result beat out. The block takes a command beat in
// every cycle: a beat is held in an input register, its command is applied to
// the pattern state in one pass of logic, and the result lands in an output
// register; a result is valid once it has passed both registers. The output
// register drains while the next command moves up, so a stall on the result
// side only holds the input when both registers are full.
// Commands are a 1 ms tick, preset start, custom start, solid colour and off;
// the configuration port sets brightness (applied at each render) and enable.
module led_blink_pattern_sequencer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Command stream.
	input  wire logic                              s_tvalid,
	output      logic                              s_tready,
	// operation[2:0], preset[5:3], red[13:6], green[21:14], blue[29:22],
	// on_time[45:30], off_time[61:46], repeats[69:62], zero fill
	input  wire logic [8*lbps_pkg::IN_BYTES-1:0]   s_tdata,
	// Result stream.
	output      logic                              m_tvalid,
	input  wire logic                              m_tready,
	// led_any[0], led_red[1], led_green[2], led_blue[3], animating[4],
	// indicated_state[8:5], zero fill
	output      logic [8*lbps_pkg::OUT_BYTES-1:0]  m_tdata,
	// Configuration write port.
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_index,
	input  wire logic [7:0]                        cfg_data
);
	import lbps_pkg::*;

	// Input register.
	logic      valid_s1;
	in_item_t  item_s1;
	logic      adv;

	// Result register.
	logic      out_valid_q;
	out_item_t out_q;

	// Configuration registers.
	logic [7:0] brightness_q;
	logic       enable_q;

	// Pattern state.
	logic        phase_q;
	logic [7:0]  count_q;
	logic        running_q;
	logic [15:0] wait_q;
	pattern_t    pat_q;
	logic [3:0]  main_q;
	logic [3:0]  pins_q;

	// Next pattern state.
	logic        phase_d;
	logic [7:0]  count_d;
	logic        running_d;
	logic [15:0] wait_d;
	pattern_t    pat_d;
	logic [3:0]  main_d;
	logic [3:0]  pins_d;

	pattern_t    start_pat;
	logic        do_start;
	logic        do_step;
	logic [7:0]  count_inc;

	// The input register moves on when the result register is free or drains.
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= s_tdata;
		end
	end

	// Command decode and one pattern step.
	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		running_d = running_q;
		wait_d    = wait_q;
		pat_d     = pat_q;
		main_d    = main_q;
		pins_d    = pins_q;
		do_start  = 1'b0;
		do_step   = 1'b0;
		start_pat = (item_s1.operation == OP_PRESET) ? preset_pattern(item_s1.preset)
			: pattern_t'{{item_s1.red, item_s1.green, item_s1.blue},
				item_s1.on_time, item_s1.off_time, item_s1.repeats};

		unique case (item_s1.operation)
			OP_TICK: begin
				if (running_q && enable_q) begin
					if (wait_q > 16'd1) begin
						wait_d = wait_q - 16'd1;
					end else begin
						wait_d  = 16'd0;
						do_step = 1'b1;
					end
				end
			end
			OP_PRESET: begin
				if (enable_q) begin
					if ((item_s1.preset != PRE_TRANSMIT) && (item_s1.preset != PRE_BUFFERING)) begin
						main_d = {1'b0, item_s1.preset};
					end
					do_start = 1'b1;
				end
			end
			OP_CUSTOM: begin
				if (enable_q) begin
					main_d   = STATE_CUSTOM;
					do_start = 1'b1;
				end
			end
			OP_SOLID: begin
				if (enable_q) begin
					running_d = 1'b0;
					wait_d    = 16'd0;
					pins_d    = render({item_s1.red, item_s1.green, item_s1.blue}, brightness_q);
				end
			end
			OP_OFF: begin
				main_d    = 4'd0;
				running_d = 1'b0;
				wait_d    = 16'd0;
				pins_d    = 4'b0000;
			end
			default: begin
			end
		endcase

		// A start loads the pattern and fires its first step at once.
		if (do_start) begin
			pat_d     = start_pat;
			phase_d   = 1'b0;
			count_d   = 8'd0;
			running_d = 1'b1;
			wait_d    = 16'd0;
			do_step   = 1'b1;
		end

		count_inc = count_d + 8'd1;

		// On phase shows the colour; off phase darkens or keeps the lit gap.
		if (do_step) begin
			if (!phase_d) begin
				pins_d = render(pat_d.colour, brightness_q);
				if (pat_d.on_ms != 16'd0) begin
					wait_d  = pat_d.on_ms;
					phase_d = 1'b1;
				end else begin
					running_d = 1'b0;
					wait_d    = 16'd0;
				end
			end else begin
				if (pat_d.off_ms != 16'd0) begin
					pins_d = 4'b0000;
					wait_d = pat_d.off_ms;
				end else begin
					wait_d = GAP_MS;
				end
				phase_d = 1'b0;
				count_d = count_inc;
				if ((pat_d.rep != 8'd0) && (count_inc >= pat_d.rep)) begin
					running_d = 1'b0;
					wait_d    = 16'd0;
				end
			end
		end
	end

	// Pattern state and config; the user must write only while idle (not checked).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= 8'd255;
			enable_q     <= 1'b1;
			phase_q      <= 1'b0;
			count_q      <= 8'd0;
			running_q    <= 1'b0;
			wait_q       <= 16'd0;
			pat_q        <= '0;
			main_q       <= 4'd0;
			pins_q       <= 4'b0000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BRIGHTNESS: brightness_q <= cfg_data;
				CFG_ENABLE: begin
					enable_q <= cfg_data[0];
					if (!cfg_data[0]) begin
						running_q <= 1'b0;
						wait_q    <= 16'd0;
						pins_q    <= 4'b0000;
					end
				end
				default: begin
				end
			endcase
		end else if (adv) begin
			phase_q   <= phase_d;
			count_q   <= count_d;
			running_q <= running_d;
			wait_q    <= wait_d;
			pat_q     <= pat_d;
			main_q    <= main_d;
			pins_q    <= pins_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.pad             <= '0;
			out_q.indicated_state <= main_d;
			out_q.animating       <= running_d;
			out_q.led_blue        <= pins_d[3];
			out_q.led_green       <= pins_d[2];
			out_q.led_red         <= pins_d[1];
			out_q.led_any         <= pins_d[0];
		end
	end

	// An empty result register never holds back the input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with an empty result register");

	// A pattern only runs while enabled.
	a_run_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> enable_q)
		else $error("pattern running while disabled");

	// A stopped pattern leaves no wait behind.
	a_idle_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (wait_q == 16'd0))
		else $error("wait left while not running");

	// Colour pins only light together with the any pin.
	a_pins_need_any: assert property (@(posedge clk) disable iff (!arst_n)
		!pins_q[0] |-> (pins_q[3:1] == 3'b000))
		else $error("colour pin lit without the any pin");

endmodule

`default_nettype wire

// ===== dv/led_blink_pattern_sequencer_tb.sv =====
// Self-checking testbench for the LED blink pattern sequencer: directed table, then random
// command runs, all checked beat by beat against a behavioral model held in this file.
// Depends on lbps_pkg and led_blink_pattern_sequencer.
`timescale 1ns / 1ps

module led_blink_pattern_sequencer_tb;
	import lbps_pkg::*;

	// Operation codes the block must ignore.
	localparam logic [2:0] OP_RSV5 = 3'd5;
	localparam logic [2:0] OP_RSV7 = 3'd7;

	localparam int RANDOM_BEATS = 800;
	localparam int HOLD_CYCLES  = 80;
	localparam int QUIET_LIMIT  = 1000;
	localparam int GAP_TICKS    = 100;
	localparam int MIX_THRESH   = 128;

	// One row of the directed table: either a register write or a command beat.
	typedef struct {
		bit          is_cfg;
		logic        cfg_idx;
		logic [7:0]  cfg_val;
		in_item_t    beat;
		bit          typed;
		out_item_t   want;
	} plan_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [8*IN_BYTES-1:0]     s_tdata = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [8*OUT_BYTES-1:0]    m_tdata;
	logic                      cfg_we = 1'b0;
	logic                      cfg_index = 1'b0;
	logic [7:0]                cfg_data = '0;

	out_item_t results_due[$];
	int        mismatches = 0;
	int        fed = 0;
	bit        calm = 1'b0;
	bit        hold_req = 1'b0;
	bit        hold_done = 1'b0;
	int        quiet = 0;

	// Model state.
	logic [7:0]  brightness_q = 8'd255;
	logic        enable_q = 1'b1;
	logic        in_off_phase = 1'b0;
	logic [7:0]  cycles_done = '0;
	logic        is_running = 1'b0;
	logic [15:0] ms_left = '0;
	pattern_t    pat = '0;
	logic [3:0]  shown_state = '0;
	logic [3:0]  pins = '0;   // {blue, green, red, any}

	led_blink_pattern_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Preset patterns as the product defines them.
	function automatic pattern_t preset_of(input logic [2:0] idx);
		pattern_t p;
		p = '0;
		case (idx)
			PRE_INIT:       p = '{24'hFFFF00, 16'd500,  16'd500,  8'd0};
			PRE_CONNECTING: p = '{24'h0000FF, 16'd200,  16'd800,  8'd0};
			PRE_CONNECTED:  p = '{24'h00FF00, 16'd1000, 16'd0,    8'd1};
			PRE_TRANSMIT:   p = '{24'h00FFFF, 16'd100,  16'd0,    8'd1};
			PRE_BUFFERING:  p = '{24'hFFA500, 16'd250,  16'd250,  8'd2};
			PRE_ERROR:      p = '{24'hFF0000, 16'd100,  16'd100,  8'd0};
			PRE_LOWPOWER:   p = '{24'h640064, 16'd2000, 16'd8000, 8'd0};
			default:        p = '0;
		endcase
		return p;
	endfunction

	// Scale the colour by brightness and pick the pins that light.
	function automatic logic [3:0] colour_to_pins(input logic [23:0] rgb);
		int unsigned r;
		int unsigned g;
		int unsigned b;
		logic [3:0]  p;
		r = (int'(rgb[23:16]) * int'(brightness_q)) / 255;
		g = (int'(rgb[15:8]) * int'(brightness_q)) / 255;
		b = (int'(rgb[7:0]) * int'(brightness_q)) / 255;
		p = 4'b0000;
		if (r != 0 || g != 0 || b != 0) begin
			p[0] = 1'b1;
			if (r > g && r > b) begin
				p[1] = 1'b1;
			end else if (g > r && g > b) begin
				p[2] = 1'b1;
			end else if (b > r && b > g) begin
				p[3] = 1'b1;
			end else begin
				// No single winner: light every channel that is bright enough.
				p[1] = (r > MIX_THRESH);
				p[2] = (g > MIX_THRESH);
				p[3] = (b > MIX_THRESH);
			end
		end
		return p;
	endfunction

	// Move the running pattern on by one phase.
	function automatic void advance_pattern();
		if (!enable_q || !is_running)
			return;
		if (!in_off_phase) begin
			pins = colour_to_pins(pat.colour);
			if (pat.on_ms != 0) begin
				ms_left = pat.on_ms;
				in_off_phase = 1'b1;
			end else begin
				is_running = 1'b0;
				ms_left = '0;
			end
		end else begin
			// A zero off time keeps the colour lit for a fixed gap.
			if (pat.off_ms != 0) begin
				pins = '0;
				ms_left = pat.off_ms;
			end else begin
				ms_left = 16'(GAP_TICKS);
			end
			in_off_phase = 1'b0;
			cycles_done = cycles_done + 8'd1;
			if (pat.rep != 0 && cycles_done >= pat.rep) begin
				is_running = 1'b0;
				ms_left = '0;
			end
		end
	endfunction

	function automatic void begin_pattern(input pattern_t p);
		pat = p;
		in_off_phase = 1'b0;
		cycles_done = '0;
		is_running = 1'b1;
		ms_left = '0;
		advance_pattern();
	endfunction

	// Apply one command to the model and return the result beat it produces.
	function automatic out_item_t predict_result(input in_item_t c);
		out_item_t r;
		pattern_t  cp;
		case (c.operation)
			OP_TICK: begin
				if (is_running && enable_q) begin
					if (ms_left > 1) begin
						ms_left = ms_left - 16'd1;
					end else begin
						ms_left = '0;
						advance_pattern();
					end
				end
			end
			OP_PRESET: begin
				if (enable_q) begin
					if (c.preset != PRE_TRANSMIT && c.preset != PRE_BUFFERING)
						shown_state = {1'b0, c.preset};
					begin_pattern(preset_of(c.preset));
				end
			end
			OP_CUSTOM: begin
				if (enable_q) begin
					shown_state = STATE_CUSTOM;
					cp.colour = {c.red, c.green, c.blue};
					cp.on_ms = c.on_time;
					cp.off_ms = c.off_time;
					cp.rep = c.repeats;
					begin_pattern(cp);
				end
			end
			OP_SOLID: begin
				if (enable_q) begin
					is_running = 1'b0;
					ms_left = '0;
					pins = colour_to_pins({c.red, c.green, c.blue});
				end
			end
			OP_OFF: begin
				shown_state = '0;
				is_running = 1'b0;
				ms_left = '0;
				pins = '0;
			end
			default: begin
			end
		endcase
		r = '0;
		r.led_any = pins[0];
		r.led_red = pins[1];
		r.led_green = pins[2];
		r.led_blue = pins[3];
		r.animating = is_running;
		r.indicated_state = shown_state;
		return r;
	endfunction

	function automatic void apply_reg(input logic idx, input logic [7:0] v);
		if (idx == CFG_BRIGHTNESS) begin
			brightness_q = v;
		end else begin
			enable_q = v[0];
			if (!enable_q) begin
				is_running = 1'b0;
				ms_left = '0;
				pins = '0;
			end
		end
	endfunction

	function automatic in_item_t cmd(input logic [2:0] op, input logic [2:0] pre,
			input logic [23:0] rgb, input logic [15:0] on_ms, input logic [15:0] off_ms,
			input logic [7:0] rep);
		in_item_t c;
		c = '0;
		c.operation = op;
		c.preset = pre;
		{c.red, c.green, c.blue} = rgb;
		c.on_time = on_ms;
		c.off_time = off_ms;
		c.repeats = rep;
		return c;
	endfunction

	function automatic out_item_t res(input logic any, input logic r, input logic g,
			input logic b, input logic anim, input logic [3:0] st);
		out_item_t o;
		o = '0;
		o.led_any = any;
		o.led_red = r;
		o.led_green = g;
		o.led_blue = b;
		o.animating = anim;
		o.indicated_state = st;
		return o;
	endfunction

	function automatic plan_row_t beat_row(input in_item_t c);
		plan_row_t row;
		row = '{default: '0};
		row.beat = c;
		return row;
	endfunction

	function automatic plan_row_t checked_row(input in_item_t c, input out_item_t w);
		plan_row_t row;
		row = beat_row(c);
		row.typed = 1'b1;
		row.want = w;
		return row;
	endfunction

	function automatic plan_row_t cfg_row(input logic idx, input logic [7:0] v);
		plan_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.cfg_idx = idx;
		row.cfg_val = v;
		return row;
	endfunction

	// Pattern times: mostly a few ms so phases turn over often.
	function automatic logic [15:0] short_ms();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)
			return 16'($urandom_range(4));
		else if (pick < 90)
			return 16'($urandom_range(5, 30));
		return 16'($urandom);
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Offer one command beat, with a random gap first, and record its expected result.
	task automatic send_beat(input in_item_t c, input bit typed, input out_item_t want);
		int        gap;
		out_item_t modeled;
		gap = (!calm && $urandom_range(99) < 20) ? $urandom_range(1, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		do @(posedge clk); while (!s_tready);
		modeled = predict_result(c);
		results_due.push_back(typed ? want : modeled);
		fed++;
	endtask

	// Stop offering beats and wait for every pending result.
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] v);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		apply_reg(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Result side: random backpressure, one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				hold_done = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 20);
			end
		end
	end

	// Compare every result beat with the oldest expectation.
	always @(posedge clk) begin
		out_item_t got;
		out_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (results_due.size() == 0) begin
				$error("result beat with no command pending: %h", got);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				check_field("led_any", want.led_any, got.led_any);
				check_field("led_red", want.led_red, got.led_red);
				check_field("led_green", want.led_green, got.led_green);
				check_field("led_blue", want.led_blue, got.led_blue);
				check_field("animating", want.animating, got.animating);
				check_field("indicated_state", want.indicated_state, got.indicated_state);
			end
		end
	end

	// Watchdog: too long without any beat moving ends the run.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("** led_blink_pattern_sequencer: FAILED **");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		plan_row_t plan[$];
		int        kind;
		int        n;
		int        pick;
		int        random_goal;
		int        calm_from;
		int        hold_at;
		int        pause_at;
		bit        paused;
		logic [2:0] pre;

		// Directed part: extremes, every command, the special cases.
		plan.push_back(checked_row(cmd(OP_TICK, PRE_OFF, 24'h0, 16'd0, 16'd0, 8'd0),
			res(0, 0, 0, 0, 0, 4'd0)));
		plan.push_back(checked_row(cmd(OP_SOLID, PRE_OFF, 24'hFFFFFF, 16'd0, 16'd0, 8'd0),
			res(1, 1, 1, 1, 0, 4'd0)));
		plan.push_back(checked_row(cmd(OP_SOLID, PRE_OFF, 24'hFF0000, 16'd0, 16'd0, 8'd0),
			res(1, 1, 0, 0, 0, 4'd0)));
		plan.push_back(checked_row(cmd(OP_PRESET, PRE_OFF, 24'h0, 16'd0, 16'd0, 8'd0),
			res(0, 0, 0, 0, 0, 4'd0)));
		plan.push_back(checked_row(cmd(OP_PRESET, PRE_INIT, 24'h0, 16'd0, 16'd0, 8'd0),
			res(1, 1, 1, 0, 1, {1'b0, PRE_INIT})));
		plan.push_back(beat_row(cmd(OP_PRESET, PRE_CONNECTING, 24'h0, 16'd0, 16'd0, 8'd0)));
		// Transmit and buffering keep the previous main state.
		plan.push_back(beat_row(cmd(OP_PRESET, PRE_TRANSMIT, 24'h0, 16'd0, 16'd0, 8'd0)));
		plan.push_back(beat_row(cmd(OP_PRESET, PRE_BUFFERING, 24'h0, 16'd0, 16'd0, 8'd0)));
		plan.push_back(beat_row(cmd(OP_PRESET, PRE_ERROR, 24'h0, 16'd0, 16'd0, 8'd0)));
		plan.push_back(beat_row(cmd(OP_PRESET, PRE_LOWPOWER, 24'h0, 16'd0, 16'd0, 8'd0)));
		plan.push_back(beat_row(cmd(OP_PRESET, PRE_CONNECTED, 24'h0, 16'd0, 16'd0, 8'd0)));
		// Custom with zero on time holds the colour and does not animate.
		plan.push_back(beat_row(cmd(OP_CUSTOM, PRE_OFF, 24'h0A141E, 16'd0, 16'd0, 8'd0)));
		// Zero off time gives the lit gap; one repeat stops after the first cycle.
		plan.push_back(beat_row(cmd(OP_CUSTOM, PRE_OFF, 24'h00FF00, 16'd2, 16'd0, 8'd1)));
		plan.push_back(beat_row(cmd(OP_TICK, PRE_OFF, 24'h0, 16'd0, 16'd0, 8'd0)));
		plan.push_back(beat_row(cmd(OP_TICK, PRE_OFF, 24'h0, 16'd0, 16'd0, 8'd0)));
		// Shortest blink, repeating forever.
		plan.push_back(beat_row(cmd(OP_CUSTOM, PRE_OFF, 24'h00FFFF, 16'd1, 16'd1, 8'd0)));
		plan.push_back(beat_row(cmd(OP_TICK, PRE_OFF, 24'h0, 16'd0, 16'd0, 8'd0)));
		// Unused operation codes change nothing.
		plan.push_back(beat_row(cmd(OP_RSV5, PRE_LOWPOWER, 24'hFFFFFF, 16'hFFFF, 16'hFFFF,
			8'hFF)));
		plan.push_back(beat_row(cmd(OP_RSV7, PRE_OFF, 24'h0, 16'd0, 16'd0, 8'd0)));
		plan.push_back(checked_row(cmd(OP_CUSTOM, PRE_LOWPOWER, 24'hFFFFFF, 16'hFFFF,
			16'hFFFF, 8'hFF), res(1, 1, 1, 1, 1, STATE_CUSTOM)));
		plan.push_back(checked_row(cmd(OP_OFF, PRE_OFF, 24'h0, 16'd0, 16'd0, 8'd0),
			res(0, 0, 0, 0, 0, 4'd0)));
		// Zero brightness renders every colour dark.
		plan.push_back(cfg_row(CFG_BRIGHTNESS, 8'd0));
		plan.push_back(checked_row(cmd(OP_SOLID, PRE_OFF, 24'hFFFFFF, 16'd0, 16'd0, 8'd0),
			res(0, 0, 0, 0, 0, 4'd0)));
		// A brightness change leaves the pins as they were until the next render.
		plan.push_back(cfg_row(CFG_BRIGHTNESS, 8'd255));
		plan.push_back(beat_row(cmd(OP_SOLID, PRE_OFF, 24'h640064, 16'd0, 16'd0, 8'd0)));
		plan.push_back(cfg_row(CFG_BRIGHTNESS, 8'd1));
		plan.push_back(beat_row(cmd(OP_TICK, PRE_OFF, 24'h0, 16'd0, 16'd0, 8'd0)));
		// Disabled: starts and colours are ignored, off still acts.
		plan.push_back(cfg_row(CFG_ENABLE, 8'd0));
		plan.push_back(beat_row(cmd(OP_PRESET, PRE_INIT, 24'h0, 16'd0, 16'd0, 8'd0)));
		plan.push_back(beat_row(cmd(OP_SOLID, PRE_OFF, 24'hFF0000, 16'd0, 16'd0, 8'd0)));
		plan.push_back(checked_row(cmd(OP_OFF, PRE_OFF, 24'h0, 16'd0, 16'd0, 8'd0),
			res(0, 0, 0, 0, 0, 4'd0)));
		plan.push_back(cfg_row(CFG_ENABLE, 8'd1));
		plan.push_back(cfg_row(CFG_BRIGHTNESS, 8'd255));

		// Reset once, at the start.
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].cfg_idx, plan[i].cfg_val);
			else
				send_beat(plan[i].beat, plan[i].typed, plan[i].want);
		end

		// Random part: mostly pattern starts followed by runs of ticks.
		random_goal = fed + RANDOM_BEATS;
		hold_at = fed + 150;
		pause_at = fed + 250;
		calm_from = fed + 400;
		paused = 1'b0;
		while (fed < random_goal) begin
			calm = (fed >= calm_from && fed < calm_from + 150);
			if (fed >= hold_at)
				hold_req = 1'b1;
			if (!paused && fed >= pause_at) begin
				paused = 1'b1;
				wait_drained();
			end
			kind = $urandom_range(99);
			if (kind < 8) begin
				if (!enable_q) begin
					write_reg(CFG_ENABLE, {7'($urandom), 1'b1});
				end else if ($urandom_range(3) == 0) begin
					write_reg(CFG_ENABLE, {7'($urandom), 1'b0});
				end else begin
					pick = $urandom_range(3);
					write_reg(CFG_BRIGHTNESS,
						(pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom));
				end
			end else if (kind < 80) begin
				if (kind < 60) begin
					send_beat(cmd(OP_CUSTOM, 3'($urandom), 24'($urandom), short_ms(),
						short_ms(), ($urandom_range(1) != 0) ? 8'($urandom_range(3))
						: 8'($urandom)), 1'b0, '0);
				end else begin
					pre = 3'($urandom);
					send_beat(cmd(OP_PRESET, pre, 24'($urandom), 16'($urandom),
						16'($urandom), 8'($urandom)), 1'b0, '0);
				end
				n = ($urandom_range(19) == 0) ? $urandom_range(100, 250)
					: $urandom_range(1, 40);
				repeat (n) begin
					send_beat(cmd(OP_TICK, 3'($urandom), 24'($urandom), 16'($urandom),
						16'($urandom), 8'($urandom)), 1'b0, '0);
				end
			end else begin
				// Noise: any operation code with any payload.
				repeat ($urandom_range(1, 4)) begin
					send_beat(cmd(3'($urandom), 3'($urandom), 24'($urandom), short_ms(),
						16'($urandom), 8'($urandom)), 1'b0, '0);
				end
			end
		end
		calm = 1'b0;

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && results_due.size() == 0)
			$display("** led_blink_pattern_sequencer: PASSED **");
		else
			$display("** led_blink_pattern_sequencer: FAILED **");
		$finish;
	end

endmodule
